FILE: hdl/brown_conrady_undistort_unit_assert.svh
// ----------------------------------------------------------------------------
// Brown-Conrady undistortion unit: assertion macros
// Implication checks on the unit's clock, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BROWN_CONRADY_UNDISTORT_UNIT_ASSERT_SVH
`define BROWN_CONRADY_UNDISTORT_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define BCU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define BCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BCU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define BCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/bcu_pkg.sv
// ----------------------------------------------------------------------------
// Brown-Conrady undistortion package
// Payload types, micro-op codes, the pass microprogram and shared helpers.
// ----------------------------------------------------------------------------
package bcu_pkg;

	localparam int COORD_W         = 32;
	localparam int MAX_PASSES_DEF  = 50;
	localparam int FRAC_BITS_DEF   = 28;
	localparam int CFG_IDX_W       = 3;
	localparam int ITER_OUT_W      = 6;
	localparam int PC_W            = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_K1 = 3'd0,
		CFG_K2 = 3'd1,
		CFG_K3 = 3'd2,
		CFG_P1 = 3'd3,
		CFG_P2 = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_distorted;
		logic signed [COORD_W-1:0] y_distorted;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_undistorted;
		logic signed [COORD_W-1:0] y_undistorted;
		logic                      converged;
		logic [ITER_OUT_W-1:0]     iterations_used;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NOP  = 4'd0,
		OP_LOAD = 4'd1,
		OP_MUL  = 4'd2,
		OP_ADD  = 4'd3,
		OP_SUB  = 4'd4,
		OP_CHK  = 4'd5,
		OP_DIV  = 4'd6,
		OP_UPD  = 4'd7
	} op_t;

	// Scratch registers first, then the constant and coefficient sources.
	typedef enum logic [4:0] {
		R_X   = 5'd0,  R_Y   = 5'd1,  R_XD  = 5'd2,  R_YD  = 5'd3,
		R_XX  = 5'd4,  R_YY  = 5'd5,  R_XY  = 5'd6,  R_R2  = 5'd7,
		R_R4  = 5'd8,  R_R6  = 5'd9,  R_L   = 5'd10, R_DX  = 5'd11,
		R_DY  = 5'd12, R_XL  = 5'd13, R_YL  = 5'd14, R_RX  = 5'd15,
		R_RY  = 5'd16, R_T0  = 5'd17, R_T1  = 5'd18, R_NX  = 5'd19,
		R_NY  = 5'd20, R_ONE = 5'd21, R_K1  = 5'd22, R_K2  = 5'd23,
		R_K3  = 5'd24, R_P1  = 5'd25, R_P2  = 5'd26
	} reg_id_t;

	localparam int NRF = 21;

	typedef struct packed {
		op_t     op;
		reg_id_t a;
		reg_id_t b;
		reg_id_t dst;
	} ucode_t;

	typedef struct packed {
		logic                  start;
		ucode_t                uc;
		logic                  out_load;
		logic                  converged;
		logic [ITER_OUT_W-1:0] used;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic conv_hit;
		logic l_small;
		logic ovf;
	} status_t;

	localparam logic [PC_W-1:0] PC_CHK = 6'd29;
	localparam logic [PC_W-1:0] PC_UPD = 6'd34;

	// One pass of the iteration as a list of micro-ops.
	function automatic ucode_t ucode(logic [PC_W-1:0] pc);
		ucode_t u;
		u = '{op: OP_NOP, a: R_X, b: R_X, dst: R_T0};
		case (pc)
			6'd0:  u = '{OP_MUL, R_X,  R_X,  R_XX};
			6'd1:  u = '{OP_MUL, R_Y,  R_Y,  R_YY};
			6'd2:  u = '{OP_MUL, R_X,  R_Y,  R_XY};
			6'd3:  u = '{OP_ADD, R_XX, R_YY, R_R2};
			6'd4:  u = '{OP_MUL, R_R2, R_R2, R_R4};
			6'd5:  u = '{OP_MUL, R_R2, R_R4, R_R6};
			6'd6:  u = '{OP_MUL, R_K1, R_R2, R_T0};
			6'd7:  u = '{OP_ADD, R_ONE, R_T0, R_L};
			6'd8:  u = '{OP_MUL, R_K2, R_R4, R_T0};
			6'd9:  u = '{OP_ADD, R_L,  R_T0, R_L};
			6'd10: u = '{OP_MUL, R_K3, R_R6, R_T0};
			6'd11: u = '{OP_ADD, R_L,  R_T0, R_L};
			6'd12: u = '{OP_ADD, R_XY, R_XY, R_T1};
			6'd13: u = '{OP_MUL, R_P1, R_T1, R_DX};
			6'd14: u = '{OP_ADD, R_XX, R_XX, R_T0};
			6'd15: u = '{OP_ADD, R_R2, R_T0, R_T0};
			6'd16: u = '{OP_MUL, R_P2, R_T0, R_T0};
			6'd17: u = '{OP_ADD, R_DX, R_T0, R_DX};
			6'd18: u = '{OP_ADD, R_YY, R_YY, R_T0};
			6'd19: u = '{OP_ADD, R_R2, R_T0, R_T0};
			6'd20: u = '{OP_MUL, R_P1, R_T0, R_DY};
			6'd21: u = '{OP_MUL, R_P2, R_T1, R_T0};
			6'd22: u = '{OP_ADD, R_DY, R_T0, R_DY};
			6'd23: u = '{OP_MUL, R_X,  R_L,  R_XL};
			6'd24: u = '{OP_MUL, R_Y,  R_L,  R_YL};
			6'd25: u = '{OP_ADD, R_XL, R_DX, R_RX};
			6'd26: u = '{OP_SUB, R_RX, R_XD, R_RX};
			6'd27: u = '{OP_ADD, R_YL, R_DY, R_RY};
			6'd28: u = '{OP_SUB, R_RY, R_YD, R_RY};
			6'd29: u = '{OP_CHK, R_RX, R_RY, R_T0};
			6'd30: u = '{OP_SUB, R_XD, R_DX, R_T0};
			6'd31: u = '{OP_DIV, R_T0, R_L,  R_NX};
			6'd32: u = '{OP_SUB, R_YD, R_DY, R_T0};
			6'd33: u = '{OP_DIV, R_T0, R_L,  R_NY};
			6'd34: u = '{OP_UPD, R_NX, R_NY, R_X};
			default: u = '{OP_NOP, R_X, R_X, R_T0};
		endcase
		return u;
	endfunction

	// Magnitude of a signed coordinate; the most negative value maps to 2^(W-1).
	function automatic logic [COORD_W-1:0] mag(logic signed [COORD_W-1:0] v);
		return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
	endfunction

endpackage

FILE: hdl/bcu_mul.sv
// ----------------------------------------------------------------------------
// Brown-Conrady undistortion multiplier
// Sign-magnitude fixed-point multiply, 16 bits of one operand per cycle,
// then rounding half away from zero and saturation.
// ----------------------------------------------------------------------------
module bcu_mul #(
	parameter int FRAC_BITS = bcu_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [bcu_pkg::COORD_W-1:0] a,
	input  logic signed [bcu_pkg::COORD_W-1:0] b,
	output logic                               done,
	output logic signed [bcu_pkg::COORD_W-1:0] p
);
	import bcu_pkg::*;

	localparam int ND  = (COORD_W + 15) / 16;
	localparam int DW  = 16 * ND;
	localparam int AW  = COORD_W + DW;
	localparam int CW  = $clog2(ND + 1);
	localparam logic [AW:0] HALF  = (AW + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [AW:0] LIM_P = (AW + 1)'({(COORD_W - 1){1'b1}});
	localparam logic [AW:0] LIM_N = LIM_P + (AW + 1)'(1);

	logic                 busy_q;
	logic [CW-1:0]        cnt_q;
	logic [COORD_W-1:0]   ma_q;
	logic [DW-1:0]        mb_q;
	logic [AW-1:0]        acc_q;
	logic                 neg_q;
	logic [COORD_W+15:0]  pp;
	logic [AW:0]          rsum;
	logic [AW:0]          qv;
	logic [AW:0]          qs;

	assign pp = ma_q * mb_q[DW-1 -: 16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(ND);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= mag(a);
			mb_q  <= DW'(mag(b));
			acc_q <= '0;
			neg_q <= a[COORD_W-1] ^ b[COORD_W-1];
		end else if (busy_q && cnt_q != '0) begin
			acc_q <= {acc_q[AW-17:0], 16'b0} + AW'(pp);
			mb_q  <= {mb_q[DW-17:0], 16'b0};
		end
	end

	always_comb begin
		rsum = {1'b0, acc_q} + HALF;
		qv   = rsum >> FRAC_BITS;
		if (neg_q) begin
			qs = (qv > LIM_N) ? LIM_N : qv;
		end else begin
			qs = (qv > LIM_P) ? LIM_P : qv;
		end
		p = neg_q ? -signed'(qs[COORD_W-1:0]) : signed'(qs[COORD_W-1:0]);
	end

	assign done = busy_q && (cnt_q == '0);

endmodule

FILE: hdl/bcu_div.sv
// ----------------------------------------------------------------------------
// Brown-Conrady undistortion divider
// Restoring division of num * 2^FRAC_BITS by den, one quotient bit per cycle,
// rounded half away from zero, with an out-of-range flag.
// ----------------------------------------------------------------------------
module bcu_div #(
	parameter int FRAC_BITS = bcu_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [bcu_pkg::COORD_W-1:0] num,
	input  logic signed [bcu_pkg::COORD_W-1:0] den,
	output logic                               done,
	output logic signed [bcu_pkg::COORD_W-1:0] q,
	output logic                               ovf
);
	import bcu_pkg::*;

	localparam int NB = COORD_W + FRAC_BITS;
	localparam int CW = $clog2(NB + 1);
	localparam logic [NB:0] LIM_P = (NB + 1)'({(COORD_W - 1){1'b1}});
	localparam logic [NB:0] LIM_N = LIM_P + (NB + 1)'(1);

	logic                busy_q;
	logic [CW-1:0]       cnt_q;
	logic [NB-1:0]       dv_q;
	logic [NB-1:0]       q_q;
	logic [COORD_W-1:0]  rem_q;
	logic [COORD_W-1:0]  d_q;
	logic                neg_q;
	logic [COORD_W:0]    r2;
	logic                ge;
	logic                rnd;
	logic [NB:0]         qr;

	assign r2 = {rem_q, dv_q[NB-1]};
	assign ge = r2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NB);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv_q  <= NB'(mag(num)) << FRAC_BITS;
			q_q   <= '0;
			rem_q <= '0;
			d_q   <= mag(den);
			neg_q <= num[COORD_W-1] ^ den[COORD_W-1];
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? COORD_W'(r2 - {1'b0, d_q}) : COORD_W'(r2);
			q_q   <= {q_q[NB-2:0], ge};
			dv_q  <= {dv_q[NB-2:0], 1'b0};
		end
	end

	always_comb begin
		rnd = {rem_q, 1'b0} >= {1'b0, d_q};
		qr  = {1'b0, q_q} + (NB + 1)'(rnd);
		ovf = neg_q ? (qr > LIM_N) : (qr > LIM_P);
		q   = neg_q ? -signed'(qr[COORD_W-1:0]) : signed'(qr[COORD_W-1:0]);
	end

	assign done = busy_q && (cnt_q == '0);

endmodule

FILE: hdl/bcu_datapath.sv
// ----------------------------------------------------------------------------
// Brown-Conrady undistortion datapath
// Scratch registers, coefficients, saturating adder, tolerance check,
// multiplier and divider, driven by micro-op commands.
// ----------------------------------------------------------------------------
module bcu_datapath #(
	parameter int FRAC_BITS = bcu_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bcu_pkg::cmd_t                       cmd,
	output bcu_pkg::status_t                    sts,
	input  bcu_pkg::in_item_t                   pt_data,
	input  logic                                cfg_valid,
	input  logic [bcu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic signed [bcu_pkg::COORD_W-1:0]  cfg_data,
	output bcu_pkg::out_item_t                  res_data
);
	import bcu_pkg::*;

	localparam int RF_AW = $clog2(NRF);
	localparam logic [COORD_W-1:0] MAXV  = {1'b0, {(COORD_W - 1){1'b1}}};
	localparam logic [COORD_W-1:0] MINV  = {1'b1, {(COORD_W - 1){1'b0}}};
	localparam logic [COORD_W-1:0] ONE_V = (FRAC_BITS >= COORD_W - 1) ? MAXV :
		COORD_W'(64'd1 << FRAC_BITS);
	localparam logic [COORD_W-1:0] EPS_V = (FRAC_BITS >= 23) ?
		COORD_W'(64'd1 << (FRAC_BITS - 23)) : COORD_W'(1);
	localparam logic [19:0] TOL_INV = 20'd1000000;

	logic signed [COORD_W-1:0] rf_q [NRF];
	logic signed [COORD_W-1:0] k1_q, k2_q, k3_q, p1_q, p2_q;
	logic signed [COORD_W-1:0] opa, opb, alu;
	logic signed [COORD_W:0]   sum;
	reg_id_t                   dst_q;
	logic                      ovf_q, conv_q, small_q;
	logic                      mul_start, mul_done, div_start, div_done, div_ovf;
	logic signed [COORD_W-1:0] mul_p, div_q;
	logic [COORD_W-1:0]        m_res, scale, s1, s2;
	logic [COORD_W+19:0]       tol_p;
	logic                      chk_conv, chk_small;
	out_item_t                 res_q;

	always_comb begin
		case (cmd.uc.a)
			R_ONE:   opa = signed'(ONE_V);
			R_K1:    opa = k1_q;
			R_K2:    opa = k2_q;
			R_K3:    opa = k3_q;
			R_P1:    opa = p1_q;
			R_P2:    opa = p2_q;
			default: opa = rf_q[cmd.uc.a[RF_AW-1:0]];
		endcase
		case (cmd.uc.b)
			R_ONE:   opb = signed'(ONE_V);
			R_K1:    opb = k1_q;
			R_K2:    opb = k2_q;
			R_K3:    opb = k3_q;
			R_P1:    opb = p1_q;
			R_P2:    opb = p2_q;
			default: opb = rf_q[cmd.uc.b[RF_AW-1:0]];
		endcase
	end

	// Saturating add and subtract.
	always_comb begin
		if (cmd.uc.op == OP_SUB) begin
			sum = {opa[COORD_W-1], opa} - {opb[COORD_W-1], opb};
		end else begin
			sum = {opa[COORD_W-1], opa} + {opb[COORD_W-1], opb};
		end
		if (sum[COORD_W] != sum[COORD_W-1]) begin
			alu = sum[COORD_W] ? signed'(MINV) : signed'(MAXV);
		end else begin
			alu = sum[COORD_W-1:0];
		end
	end

	// Tolerance test: max residual times one million against the scale.
	always_comb begin
		m_res = (mag(rf_q[R_RX]) > mag(rf_q[R_RY])) ? mag(rf_q[R_RX]) : mag(rf_q[R_RY]);
		s1    = (mag(rf_q[R_XD]) > mag(rf_q[R_YD])) ? mag(rf_q[R_XD]) : mag(rf_q[R_YD]);
		s2    = (mag(rf_q[R_XL]) > mag(rf_q[R_YL])) ? mag(rf_q[R_XL]) : mag(rf_q[R_YL]);
		scale = (s1 > s2) ? s1 : s2;
		if (ONE_V > scale) begin
			scale = ONE_V;
		end
		tol_p     = m_res * TOL_INV;
		chk_conv  = tol_p <= (COORD_W + 20)'(scale);
		chk_small = mag(rf_q[R_L]) < EPS_V;
	end

	assign mul_start = cmd.start && (cmd.uc.op == OP_MUL);
	assign div_start = cmd.start && (cmd.uc.op == OP_DIV);

	bcu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (opa),
		.b      (opb),
		.done   (mul_done),
		.p      (mul_p)
	);

	bcu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (opa),
		.den    (opb),
		.done   (div_done),
		.q      (div_q),
		.ovf    (div_ovf)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dst_q <= cmd.uc.dst;
			case (cmd.uc.op)
				OP_LOAD: begin
					rf_q[R_X]  <= pt_data.x_distorted;
					rf_q[R_XD] <= pt_data.x_distorted;
					rf_q[R_Y]  <= pt_data.y_distorted;
					rf_q[R_YD] <= pt_data.y_distorted;
				end
				OP_ADD, OP_SUB: begin
					rf_q[cmd.uc.dst[RF_AW-1:0]] <= alu;
				end
				OP_UPD: begin
					rf_q[R_X] <= rf_q[R_NX];
					rf_q[R_Y] <= rf_q[R_NY];
				end
				default: begin
				end
			endcase
		end
		if (mul_done) begin
			rf_q[dst_q[RF_AW-1:0]] <= mul_p;
		end
		if (div_done) begin
			rf_q[dst_q[RF_AW-1:0]] <= div_q;
		end
		if (cmd.out_load) begin
			res_q.x_undistorted   <= rf_q[R_X];
			res_q.y_undistorted   <= rf_q[R_Y];
			res_q.converged       <= cmd.converged;
			res_q.iterations_used <= cmd.used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q   <= 1'b0;
			conv_q  <= 1'b0;
			small_q <= 1'b0;
		end else begin
			if (cmd.start && cmd.uc.op == OP_LOAD) begin
				ovf_q <= 1'b0;
			end else if (div_done && div_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.start && cmd.uc.op == OP_CHK) begin
				conv_q  <= chk_conv;
				small_q <= chk_small;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= '0;
			k2_q <= '0;
			k3_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_K1:  k1_q <= cfg_data;
				CFG_K2:  k2_q <= cfg_data;
				CFG_K3:  k3_q <= cfg_data;
				CFG_P1:  p1_q <= cfg_data;
				CFG_P2:  p2_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign sts.done     = mul_done | div_done;
	assign sts.conv_hit = conv_q;
	assign sts.l_small  = small_q;
	assign sts.ovf      = ovf_q;
	assign res_data     = res_q;

endmodule

FILE: hdl/bcu_ctrl.sv
// ----------------------------------------------------------------------------
// Brown-Conrady undistortion controller
// Walks the pass microprogram, counts passes, decides when iteration stops
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module bcu_ctrl #(
	parameter int MAX_PASSES = bcu_pkg::MAX_PASSES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pt_valid,
	output logic             pt_stall,
	output logic             res_valid,
	input  logic             res_stall,
	output bcu_pkg::cmd_t    cmd,
	input  bcu_pkg::status_t sts
);
	import bcu_pkg::*;

	localparam int IW = $clog2(MAX_PASSES + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ISSUE = 5'b00010,
		S_WAIT  = 5'b00100,
		S_EVAL  = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t                state_q, state_d;
	logic [PC_W-1:0]       pc_q, pc_d;
	logic [IW-1:0]         it_q, it_d;
	logic                  conv_q, conv_d;
	logic [ITER_OUT_W-1:0] used_q, used_d;
	logic                  res_valid_q;

	always_comb begin
		state_d       = state_q;
		pc_d          = pc_q;
		it_d          = it_q;
		conv_d        = conv_q;
		used_d        = used_q;
		cmd           = '0;
		cmd.uc        = ucode(pc_q);
		cmd.converged = conv_q;
		cmd.used      = used_q;
		case (state_q)
			S_IDLE: begin
				if (pt_valid) begin
					cmd.start  = 1'b1;
					cmd.uc.op  = OP_LOAD;
					pc_d       = '0;
					it_d       = '0;
					state_d    = S_ISSUE;
				end
			end
			S_ISSUE: begin
				if (pc_q == PC_UPD) begin
					if (sts.ovf) begin
						conv_d  = 1'b0;
						used_d  = ITER_OUT_W'(MAX_PASSES);
						state_d = S_FIN;
					end else begin
						cmd.start = 1'b1;
						it_d      = it_q + 1'b1;
						pc_d      = '0;
					end
				end else begin
					cmd.start = 1'b1;
					case (cmd.uc.op)
						OP_MUL, OP_DIV: state_d = S_WAIT;
						OP_CHK:         state_d = S_EVAL;
						default:        pc_d    = pc_q + 1'b1;
					endcase
				end
			end
			S_WAIT: begin
				if (sts.done) begin
					pc_d    = pc_q + 1'b1;
					state_d = S_ISSUE;
				end
			end
			S_EVAL: begin
				if (sts.conv_hit) begin
					conv_d  = 1'b1;
					used_d  = ITER_OUT_W'(it_q);
					state_d = S_FIN;
				end else if (it_q == IW'(MAX_PASSES) || sts.l_small) begin
					conv_d  = 1'b0;
					used_d  = ITER_OUT_W'(MAX_PASSES);
					state_d = S_FIN;
				end else begin
					pc_d    = pc_q + 1'b1;
					state_d = S_ISSUE;
				end
			end
			S_FIN: begin
				if (!res_valid_q || !res_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			it_q        <= '0;
			conv_q      <= 1'b0;
			used_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			it_q    <= it_d;
			conv_q  <= conv_d;
			used_q  <= used_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign pt_stall  = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

endmodule

FILE: hdl/brown_conrady_undistort_unit.sv
// ----------------------------------------------------------------------------
// Brown-Conrady undistortion unit
// Inverts the Brown-Conrady lens model for one normalized point by
// fixed-point iteration in signed fixed point with saturating arithmetic.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   point     pt_valid / pt_stall     pt_data  (x_distorted, y_distorted)
//   result    res_valid / res_stall   res_data (x/y_undistorted, converged,
//                                               iterations_used)
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A point is loaded, runs up to MAX_PASSES + 1 passes of the microprogram and
// is then wrapped up into the output register. The pass time is set by the
// bit-serial divider, COORD_W + FRAC_BITS quotient bits for each of the two
// quotients, and by 14 multiplies at 16 bits per cycle.
// Reset clears the coefficients to zero and returns the controller to idle.
// A finished result waits in the output register while the next point is
// taken; only a second result waiting on a stalled output holds the unit.
//
module brown_conrady_undistort_unit #(
	parameter int MAX_PASSES = bcu_pkg::MAX_PASSES_DEF,
	parameter int FRAC_BITS  = bcu_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pt_valid,
	output logic                               pt_stall,
	input  bcu_pkg::in_item_t                  pt_data,
	output logic                               res_valid,
	input  logic                               res_stall,
	output bcu_pkg::out_item_t                 res_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bcu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic signed [bcu_pkg::COORD_W-1:0] cfg_data
);
	import bcu_pkg::*;

`include "brown_conrady_undistort_unit_assert.svh"

	cmd_t    cmd;
	status_t sts;

	// Coefficient writes are always taken; the user is to issue them only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;

	// The controller sequences the micro-ops of one pass and decides when to stop.
	bcu_ctrl #(.MAX_PASSES(MAX_PASSES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the iterate, intermediates, coefficients and result.
	bcu_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pt_data   (pt_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_data  (res_data)
	);

	// An accepted point must start a load of the iterate in the same cycle.
	`BCU_ASSERT_IMPLIES(a_load_on_accept, clk, arst_n, pt_valid && !pt_stall, cmd.start && cmd.uc.op == OP_LOAD, "accepted point did not load")
	// Once a point is taken the unit is busy in the next cycle.
	`BCU_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, pt_valid && !pt_stall, pt_stall, "unit not busy after accept")
	// An unconverged result always reports the pass limit.
	`BCU_ASSERT_IMPLIES(a_unconv_limit, clk, arst_n, res_valid && !res_data.converged, res_data.iterations_used == ITER_OUT_W'(MAX_PASSES), "unconverged result without pass limit")

endmodule
